FILE: hdl/assert_macros.svh
// Assertion macros shared by the slot pool RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define GSP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define GSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hdl/gsp_pkg.sv
// Shared types and constants of the generational slot pool.
package gsp_pkg;

   // Fixed field widths
   localparam int OP_W    = 3;
   localparam int IDX_W   = 6;
   localparam int GEN_W   = 32;
   localparam int STAT_W  = 2;
   localparam int CNT_W   = 2;
   localparam int CFG_W   = 7;

   // Hard limit on addressable slots
   localparam int INDEX_LIMIT = 64;

   // Operation codes
   localparam logic [OP_W-1:0] OP_ACQUIRE    = 3'd0;
   localparam logic [OP_W-1:0] OP_ATTACH     = 3'd1;
   localparam logic [OP_W-1:0] OP_TRY_ATTACH = 3'd2;
   localparam logic [OP_W-1:0] OP_DETACH     = 3'd3;
   localparam logic [OP_W-1:0] OP_READ_GEN   = 3'd4;

   // Status codes
   localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_REFUSED   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 2'd2;
   localparam logic [STAT_W-1:0] STAT_COUNT     = 2'd3;

   localparam logic [CNT_W-1:0] COUNT_MAX = 2'd3;

   // slots_enabled after reset
   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // latch request and read slot entry
      logic execute;   // update slot state and load response
   } ctrl_cmd_type;

endpackage

FILE: hdl/gsp_ctrl.sv
// Controller state machine of the slot pool: sequences capture and execute.
`include "assert_macros.svh"

module gsp_ctrl
   import gsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ctrl_cmd_type cmd
);

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Handshake and commands
   always_comb begin
      req_ready   = (state_ff == S_IDLE);
      cmd.capture = req_valid && req_ready;
      cmd.execute = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   end

   // Next state; response slot frees on take, fills on execute
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (cmd.capture) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (cmd.execute) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `GSP_ASSERT_NEXT(a_capture_to_exec, clock, reset, cmd.capture, state_ff == S_EXEC)
   `GSP_ASSERT_NEXT(a_execute_fills_rsp, clock, reset, cmd.execute, rsp_valid_ff)

endmodule

FILE: hdl/gsp_dpath.sv
// Datapath of the slot pool: busy flags, slot memory, free search and update.
`include "assert_macros.svh"

module gsp_dpath
   import gsp_pkg::*;
#(
   parameter int SLOT_COUNT = 64
)
(
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   input  logic                csr_write,
   input  logic [CFG_W-1:0]    csr_slots_enabled,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [IDX_W-1:0]    req_slot_index,
   input  logic [GEN_W-1:0]    req_expected_generation,
   output logic [STAT_W-1:0]   rsp_status,
   output logic [IDX_W-1:0]    rsp_granted_index,
   output logic [GEN_W-1:0]    rsp_generation_out,
   output logic                rsp_slot_freed
);

   localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [SLOT_COUNT-1:0] ONE_VEC = SLOT_COUNT'(1);

   // Configuration
   logic [CFG_W-1:0]  cfg_ff;
   logic [CFG_W-1:0]  active_n;

   // Slot state: busy flags and entry valid bits in flops, {count, gen} in memory
   logic [SLOT_COUNT-1:0]     busy_ff, busy_in;
   logic [SLOT_COUNT-1:0]     gen_valid_ff;
   logic [CNT_W+GEN_W-1:0]    slot_mem [SLOT_COUNT];

   // Captured request
   logic [OP_W-1:0]           op_ff;
   logic [GEN_W-1:0]          want_ff;
   logic [ADDR_W-1:0]         addr_ff;
   logic [IDX_W-1:0]          grant_ff;
   logic                      found_ff;
   logic                      idx_ok_ff;
   logic                      entry_valid_ff;
   logic [CNT_W+GEN_W-1:0]    entry_ff;

   // Free search
   logic [SLOT_COUNT-1:0]     en_mask;
   logic [SLOT_COUNT-1:0]     free_vec;
   logic [SLOT_COUNT-1:0]     lowest_free;
   logic [IDX_W-1:0]          grant_c;
   logic                      found_c;
   logic                      idx_ok_c;
   logic [ADDR_W-1:0]         addr_c;

   // Execute results
   logic [CNT_W-1:0]          cur_count;
   logic [GEN_W-1:0]          cur_gen;
   logic                      cur_busy;
   logic [STAT_W-1:0]         status_c;
   logic [IDX_W-1:0]          granted_c;
   logic [GEN_W-1:0]          gen_out_c;
   logic                      freed_c;
   logic                      wr_en_c;
   logic [CNT_W-1:0]          wr_count_c;
   logic [GEN_W-1:0]          wr_gen_c;
   logic                      set_busy_c;
   logic                      clr_busy_c;

   // Response registers
   logic [STAT_W-1:0]         status_ff;
   logic [IDX_W-1:0]          granted_ff;
   logic [GEN_W-1:0]          gen_out_ff;
   logic                      freed_ff;

   // Slots in use, clamped to the storage depth
   assign active_n = (cfg_ff > CFG_W'(SLOT_COUNT)) ? CFG_W'(SLOT_COUNT) : cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_write) begin
         cfg_ff <= csr_slots_enabled;
      end
   end

   // Lowest free enabled slot: isolate lowest set bit, then encode
   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         en_mask[i] = (CFG_W'(i) < active_n);
      end
      free_vec    = ~busy_ff & en_mask;
      lowest_free = free_vec & (~free_vec + ONE_VEC);
      found_c     = |free_vec;
      grant_c     = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         grant_c = grant_c | (lowest_free[i] ? IDX_W'(i) : IDX_W'(0));
      end
   end

   assign idx_ok_c = ({1'b0, req_slot_index} < active_n);
   assign addr_c   = (req_operation == OP_ACQUIRE) ? grant_c[ADDR_W-1:0]
                                                   : req_slot_index[ADDR_W-1:0];

   // Capture request and read the slot entry
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff          <= req_operation;
         want_ff        <= req_expected_generation;
         addr_ff        <= addr_c;
         grant_ff       <= grant_c;
         found_ff       <= found_c;
         idx_ok_ff      <= idx_ok_c;
         entry_valid_ff <= gen_valid_ff[addr_c];
         entry_ff       <= slot_mem[addr_c];
      end
      if (cmd.execute && wr_en_c) begin
         slot_mem[addr_ff] <= {wr_count_c, wr_gen_c};
      end
   end

   // Entry that was never written reads as zero
   assign cur_count = entry_valid_ff ? entry_ff[CNT_W+GEN_W-1:GEN_W] : '0;
   assign cur_gen   = entry_valid_ff ? entry_ff[GEN_W-1:0] : '0;
   assign cur_busy  = busy_ff[addr_ff];

   // Operation decode and slot update
   always_comb begin
      status_c   = STAT_REFUSED;
      granted_c  = '0;
      gen_out_c  = '0;
      freed_c    = 1'b0;
      wr_en_c    = 1'b0;
      wr_count_c = cur_count;
      wr_gen_c   = cur_gen;
      set_busy_c = 1'b0;
      clr_busy_c = 1'b0;
      case (op_ff)
         OP_ACQUIRE: begin
            if (found_ff) begin
               status_c   = STAT_DONE;
               granted_c  = grant_ff;
               gen_out_c  = cur_gen + 1'b1;
               wr_en_c    = 1'b1;
               wr_count_c = '0;
               wr_gen_c   = cur_gen + 1'b1;
               set_busy_c = 1'b1;
            end
         end
         OP_ATTACH, OP_TRY_ATTACH, OP_DETACH, OP_READ_GEN: begin
            if (!idx_ok_ff) begin
               status_c = STAT_BAD_INDEX;
            end else begin
               gen_out_c = cur_gen;
               if (op_ff == OP_READ_GEN) begin
                  status_c = STAT_DONE;
               end else if (op_ff == OP_DETACH) begin
                  if (cur_count == '0) begin
                     status_c = STAT_COUNT;
                  end else begin
                     status_c   = STAT_DONE;
                     wr_en_c    = 1'b1;
                     wr_count_c = cur_count - 1'b1;
                     if (cur_count == CNT_W'(1)) begin
                        clr_busy_c = 1'b1;
                        freed_c    = 1'b1;
                     end
                  end
               end else if (op_ff == OP_TRY_ATTACH && (!cur_busy || cur_gen != want_ff)) begin
                  status_c = STAT_REFUSED;
               end else if (cur_count == COUNT_MAX) begin
                  status_c = STAT_COUNT;
               end else begin
                  status_c   = STAT_DONE;
                  wr_en_c    = 1'b1;
                  wr_count_c = cur_count + 1'b1;
               end
            end
         end
         default: begin
            status_c = STAT_REFUSED;
         end
      endcase
   end

   // Busy flag update
   always_comb begin
      busy_in = busy_ff;
      if (cmd.execute && set_busy_c) begin
         busy_in[addr_ff] = 1'b1;
      end
      if (cmd.execute && clr_busy_c) begin
         busy_in[addr_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= '0;
         gen_valid_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         if (cmd.execute && wr_en_c) begin
            gen_valid_ff[addr_ff] <= 1'b1;
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff  <= status_c;
         granted_ff <= granted_c;
         gen_out_ff <= gen_out_c;
         freed_ff   <= freed_c;
      end
   end

   assign rsp_status         = status_ff;
   assign rsp_granted_index  = granted_ff;
   assign rsp_generation_out = gen_out_ff;
   assign rsp_slot_freed     = freed_ff;

   `GSP_ASSERT_NOW(a_acquire_takes_free, clock, reset, cmd.execute && op_ff == OP_ACQUIRE && found_ff, !busy_ff[addr_ff])
   `GSP_ASSERT_NEXT(a_write_marks_valid, clock, reset, cmd.execute && wr_en_c, gen_valid_ff[$past(addr_ff)])

endmodule

FILE: hdl/generational_slot_pool_core.sv
// Generational slot pool: acquire, attach, try attach, detach and generation read.
// Each request transaction starts in the accept cycle: the lowest free slot is found
// by a priority encoder over the busy flags and the addressed slot entry is read from
// the slot memory into a register. Then, in the execute state, the entry is updated
// (read-modify-write of count and generation) and the result is loaded into the
// response register. A new request is accepted the cycle after the update, even while
// the previous response waits to be taken; a response still held stalls the update.
// Slot entries carry valid bits cleared by reset, so no clearing pass is run and the block
// is ready right after reset. The user must write the slots_enabled register through the csr
// port only while the block is idle; the block itself does not enforce this. Slot indexes at or above the
// smaller of slots_enabled, MAX_SLOTS and 64 are rejected as bad indexes.
module generational_slot_pool_core
   import gsp_pkg::*;
#(
   parameter int MAX_SLOTS = 64
)
(
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CFG_W-1:0]    csr_slots_enabled,
   // request
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [IDX_W-1:0]    req_slot_index,
   input  logic [GEN_W-1:0]    req_expected_generation,
   // response
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STAT_W-1:0]   rsp_status,
   output logic [IDX_W-1:0]    rsp_granted_index,
   output logic [GEN_W-1:0]    rsp_generation_out,
   output logic                rsp_slot_freed
);

   localparam int SLOT_COUNT = (MAX_SLOTS < INDEX_LIMIT) ? MAX_SLOTS : INDEX_LIMIT;

   ctrl_cmd_type cmd;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   gsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   gsp_dpath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_dpath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .csr_write               (csr_valid && csr_ready),
      .csr_slots_enabled       (csr_slots_enabled),
      .req_operation           (req_operation),
      .req_slot_index          (req_slot_index),
      .req_expected_generation (req_expected_generation),
      .rsp_status              (rsp_status),
      .rsp_granted_index       (rsp_granted_index),
      .rsp_generation_out      (rsp_generation_out),
      .rsp_slot_freed          (rsp_slot_freed)
   );

endmodule

FILE: tb/generational_slot_pool_core_tb.sv
// Self-checking testbench for generational_slot_pool_core: directed and random slot transactions.
module generational_slot_pool_core_tb;
   import gsp_pkg::*;

   localparam int POOL_SLOTS = 64;
   localparam int NUM_PHASES = 10;

   // How try attach picks its generation when the request is put on the bus
   typedef enum {GEN_LITERAL, GEN_CURRENT, GEN_NEAR} gen_pick_type;

   typedef struct {
      logic [OP_W-1:0]  op;
      logic [IDX_W-1:0] idx;
      logic [GEN_W-1:0] gen;
      gen_pick_type     pick;
   } slot_req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [IDX_W-1:0]  granted;
      logic [GEN_W-1:0]  gen;
      logic              freed;
   } pool_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CFG_W-1:0]    csr_slots_enabled = CFG_RESET;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_operation = OP_READ_GEN;
   logic [IDX_W-1:0]    req_slot_index = '0;
   logic [GEN_W-1:0]    req_expected_generation = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STAT_W-1:0]   rsp_status;
   logic [IDX_W-1:0]    rsp_granted_index;
   logic [GEN_W-1:0]    rsp_generation_out;
   logic                rsp_slot_freed;

   generational_slot_pool_core #(.MAX_SLOTS(POOL_SLOTS)) u_dut (
      .clock                   (clock),
      .reset                   (reset),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_slots_enabled       (csr_slots_enabled),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_operation           (req_operation),
      .req_slot_index          (req_slot_index),
      .req_expected_generation (req_expected_generation),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_status              (rsp_status),
      .rsp_granted_index       (rsp_granted_index),
      .rsp_generation_out      (rsp_generation_out),
      .rsp_slot_freed          (rsp_slot_freed)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Shadow pool state and configuration
   logic [CFG_W-1:0] cfg_slots = CFG_RESET;
   logic             shadow_busy [POOL_SLOTS];
   logic [GEN_W-1:0] shadow_gen  [POOL_SLOTS];
   logic [CNT_W-1:0] shadow_count[POOL_SLOTS];

   slot_req_type    pending_reqs[$];
   pool_result_type expected_results[$];

   int  error_count   = 0;
   int  sent_count    = 0;
   int  checked_count = 0;
   int  req_gap       = 0;
   int  rsp_stall     = 0;
   bit  quiet_run     = 1'b0;

   slot_req_type     next_req;
   logic [GEN_W-1:0] next_gen;
   pool_result_type  got_result;
   pool_result_type  want_result;

   initial begin
      for (int i = 0; i < POOL_SLOTS; i++) begin
         shadow_busy[i]  = 1'b0;
         shadow_gen[i]   = '0;
         shadow_count[i] = '0;
      end
   end

   function automatic int usable_slots();
      int n;
      n = cfg_slots;
      if (n > POOL_SLOTS) n = POOL_SLOTS;
      if (n > INDEX_LIMIT) n = INDEX_LIMIT;
      return n;
   endfunction

   // Apply one request to the shadow pool and return the response it should produce
   function automatic pool_result_type pool_apply(input logic [OP_W-1:0] op,
                                                  input logic [IDX_W-1:0] idx,
                                                  input logic [GEN_W-1:0] want);
      pool_result_type r;
      int n;
      bit found;
      r = '0;
      r.status = STAT_REFUSED;
      n = usable_slots();
      found = 1'b0;
      if (op == OP_ACQUIRE) begin
         for (int i = 0; i < n && !found; i++) begin
            if (!shadow_busy[i]) begin
               shadow_busy[i]  = 1'b1;
               shadow_gen[i]   = shadow_gen[i] + 32'd1;
               shadow_count[i] = '0;
               r.status  = STAT_DONE;
               r.granted = IDX_W'(i);
               r.gen     = shadow_gen[i];
               found     = 1'b1;
            end
         end
      end else if (op <= OP_READ_GEN) begin
         if (idx >= n) begin
            r.status = STAT_BAD_INDEX;
         end else begin
            r.gen = shadow_gen[idx];
            case (op)
               OP_READ_GEN: begin
                  r.status = STAT_DONE;
               end
               OP_ATTACH: begin
                  if (shadow_count[idx] >= COUNT_MAX) begin
                     r.status = STAT_COUNT;
                  end else begin
                     shadow_count[idx] = shadow_count[idx] + 1'b1;
                     r.status = STAT_DONE;
                  end
               end
               OP_TRY_ATTACH: begin
                  if (!shadow_busy[idx] || shadow_gen[idx] != want) begin
                     r.status = STAT_REFUSED;
                  end else if (shadow_count[idx] >= COUNT_MAX) begin
                     r.status = STAT_COUNT;
                  end else begin
                     shadow_count[idx] = shadow_count[idx] + 1'b1;
                     r.status = STAT_DONE;
                  end
               end
               default: begin
                  // detach
                  if (shadow_count[idx] == 0) begin
                     r.status = STAT_COUNT;
                  end else begin
                     shadow_count[idx] = shadow_count[idx] - 1'b1;
                     if (shadow_count[idx] == 0) begin
                        shadow_busy[idx] = 1'b0;
                        r.freed = 1'b1;
                     end
                     r.status = STAT_DONE;
                  end
               end
            endcase
         end
      end
      return r;
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (quiet_run) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic slot_req_type random_req();
      slot_req_type t;
      int n;
      int r;
      n = usable_slots();
      r = $urandom_range(0, 99);
      if (r < 20)      t.op = OP_ACQUIRE;
      else if (r < 35) t.op = OP_ATTACH;
      else if (r < 60) t.op = OP_TRY_ATTACH;
      else if (r < 85) t.op = OP_DETACH;
      else if (r < 95) t.op = OP_READ_GEN;
      else             t.op = OP_W'($urandom_range(5, 7));
      // keep most indexes inside the enabled range so slots cycle through their life
      if (n > 0 && $urandom_range(0, 9) != 0) t.idx = IDX_W'($urandom_range(0, n - 1));
      else                                    t.idx = IDX_W'($urandom_range(0, 63));
      t.gen = $urandom;
      t.pick = GEN_LITERAL;
      if (t.op == OP_TRY_ATTACH) begin
         r = $urandom_range(0, 9);
         if (r < 6)      t.pick = GEN_CURRENT;
         else if (r < 8) t.pick = GEN_NEAR;
      end
      return t;
   endfunction

   task automatic push_req(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [GEN_W-1:0] gen);
      slot_req_type t;
      t.op   = op;
      t.idx  = idx;
      t.gen  = gen;
      t.pick = GEN_LITERAL;
      pending_reqs.push_back(t);
   endtask

   task automatic push_random(input int count);
      repeat (count) pending_reqs.push_back(random_req());
   endtask

   // Wait until every request is sent and every response is back, then let the pipe settle
   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_slots_enabled(input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_valid         <= 1'b1;
      csr_slots_enabled <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      cfg_slots = value;
      @(negedge clock);
   endtask

   // Request driver: one transaction at a time from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(pool_apply(req_operation, req_slot_index,
                                                  req_expected_generation));
            void'(pending_reqs.pop_front());
            sent_count++;
            req_gap = pick_gap();
         end
         if (!(req_valid && !req_ready)) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               next_req = pending_reqs[0];
               case (next_req.pick)
                  GEN_CURRENT: next_gen = shadow_gen[next_req.idx];
                  GEN_NEAR:    next_gen = shadow_gen[next_req.idx] + $urandom_range(0, 2) - 1;
                  default:     next_gen = next_req.gen;
               endcase
               req_operation           <= next_req.op;
               req_slot_index          <= next_req.idx;
               req_expected_generation <= next_gen;
               req_valid               <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_result = '{rsp_status, rsp_granted_index, rsp_generation_out, rsp_slot_freed};
            if (expected_results.size() == 0) begin
               $error("response transaction with no request outstanding");
               error_count++;
            end else begin
               want_result = expected_results.pop_front();
               checked_count++;
               if (got_result.status !== want_result.status) begin
                  $error("status: expected %0d, got %0d", want_result.status, got_result.status);
                  error_count++;
               end
               if (got_result.granted !== want_result.granted) begin
                  $error("granted_index: expected %0d, got %0d",
                         want_result.granted, got_result.granted);
                  error_count++;
               end
               if (got_result.gen !== want_result.gen) begin
                  $error("generation_out: expected %0h, got %0h", want_result.gen, got_result.gen);
                  error_count++;
               end
               if (got_result.freed !== want_result.freed) begin
                  $error("slot_freed: expected %0d, got %0d", want_result.freed, got_result.freed);
                  error_count++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_stall = pick_gap();
         end
      end
   end

   // Stimulus sequence
   logic [CFG_W-1:0] phase_cfg [NUM_PHASES];
   int               phase_len [NUM_PHASES];

   initial begin
      phase_cfg = '{7'd2, 7'd0, 7'd1, 7'd127, 7'd6, 7'd64, 7'd100, 7'd4, 7'd65, 7'd0};
      phase_cfg[NUM_PHASES-1] = CFG_W'($urandom_range(1, 127));
      phase_len = '{60, 40, 80, 120, 140, 140, 120, 140, 120, 120};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: slot life cycle at the reset slot count
      push_req(OP_READ_GEN,   6'd0,  32'h0);
      push_req(OP_ACQUIRE,    6'd0,  32'h0);
      push_req(OP_TRY_ATTACH, 6'd0,  32'h1);
      push_req(OP_TRY_ATTACH, 6'd0,  32'hFFFF_FFFF);   // tag mismatch
      push_req(OP_TRY_ATTACH, 6'd5,  32'h0);           // free slot refuses
      push_req(OP_ATTACH,     6'd0,  32'h0);
      push_req(OP_ATTACH,     6'd0,  32'h0);
      push_req(OP_ATTACH,     6'd0,  32'h0);           // count saturated
      push_req(OP_TRY_ATTACH, 6'd0,  32'h1);           // matches but saturated
      push_req(OP_DETACH,     6'd0,  32'h0);
      push_req(OP_DETACH,     6'd0,  32'h0);
      push_req(OP_DETACH,     6'd0,  32'h0);           // drops to zero, frees
      push_req(OP_DETACH,     6'd0,  32'h0);           // underflow
      push_req(OP_ATTACH,     6'd7,  32'h0);           // attach on a free slot
      push_req(OP_ACQUIRE,    6'd0,  32'h0);
      push_req(OP_DETACH,     6'd7,  32'h0);           // frees a slot never acquired
      push_req(OP_READ_GEN,   6'd63, 32'hFFFF_FFFF);
      push_req(3'd5,          6'd63, 32'hFFFF_FFFF);   // unknown operations
      push_req(3'd6,          6'd63, 32'h0);
      push_req(3'd7,          6'd0,  32'hFFFF_FFFF);
      push_req(OP_ACQUIRE,    6'd0,  32'h0);
      push_req(OP_DETACH,     6'd0,  32'h0);           // busy slot with no ends

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         write_slots_enabled(phase_cfg[p]);
         quiet_run = (p % 3 == 2);
         // pool full and out-of-range indexes
         push_req(OP_ACQUIRE,    6'd0,  32'h0);
         push_req(OP_READ_GEN,   6'd63, 32'h0);
         push_req(OP_DETACH,     phase_cfg[p][IDX_W-1:0], 32'h0);
         push_random(phase_len[p] / 2);
         // sender holds off until every response of the first half is in
         wait_drained();
         push_random(phase_len[p] - phase_len[p] / 2);
      end

      wait_drained();
      repeat (20) @(negedge clock);
      $display("ran %0d request transactions over %0d slot-count settings, %0d responses checked",
               sent_count, NUM_PHASES + 1, checked_count);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("generational_slot_pool_core_tb OK");
      end else begin
         $display("generational_slot_pool_core_tb NOT OK");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("timeout: %0d responses still outstanding", expected_results.size());
      $display("generational_slot_pool_core_tb NOT OK");
      $finish;
   end

endmodule
